// ----- sv/doe_pkg.sv -----
// ----------------------------------------------------------------------------
// doe_pkg: shared types, constants and microcode for the oscillator stepper
// Register map, reset values, datapath control word, sequencer program and
// the saturating arithmetic helpers used by the Q16.16 datapath.
// ----------------------------------------------------------------------------
package doe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 31;
  localparam int unsigned AddrW = 5;
  localparam int unsigned PcW   = 4;

  localparam logic [PcW-1:0] LoadPc = PcW'(13);

  localparam logic signed [DataW-1:0] DampingReset  = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] StiffReset    = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] ForcingReset  = 32'sh000A_0000;
  localparam logic [StepW-1:0]        StepReset     = 31'd6554;
  localparam logic signed [DataW-1:0] StartPosReset = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] StartVelReset = 32'sh0000_0000;

  localparam logic [15:0] QHalf = 16'h8000;

  typedef enum logic [2:0] {
    REG_DAMPING   = 3'd0,
    REG_STIFFNESS = 3'd1,
    REG_FORCING   = 3'd2,
    REG_TIME_STEP = 3'd3,
    REG_START_POS = 3'd4,
    REG_START_VEL = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } seq_state_t;

  typedef enum logic [2:0] {
    OPA_C  = 3'd0,
    OPA_K  = 3'd1,
    OPA_DT = 3'd2,
    OPA_XC = 3'd3,
    OPA_TS = 3'd4
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_VL = 3'd0,
    OPB_XL = 3'd1,
    OPB_VC = 3'd2,
    OPB_XC = 3'd3,
    OPB_TS = 3'd4,
    OPB_TA = 3'd5
  } opb_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP      = 4'd0,
    ALU_TS       = 4'd1,
    ALU_ACC_LOAD = 4'd2,
    ALU_ACC_FIN  = 4'd3,
    ALU_ADD_XL   = 4'd4,
    ALU_ADD_VL   = 4'd5,
    ALU_ADD_XC   = 4'd6,
    ALU_ADD_VC   = 4'd7,
    ALU_LOAD     = 4'd8
  } alu_op_t;

  typedef struct packed {
    logic           mul_en;
    opa_sel_t       a_sel;
    opb_sel_t       b_sel;
    alu_op_t        alu_op;
    logic           jmp_restart;
    logic           last;
    logic [PcW-1:0] jmp_tgt;
  } uword_t;

  typedef struct packed {
    logic                    clip;
    logic signed [DataW-1:0] val;
  } sat_t;

  // The ALU field of a word consumes the product issued by an earlier word, once
  // it has passed the multiplier register and then the rounding register.
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      4'd0: begin
        w.mul_en = 1'b1; w.a_sel = OPA_XC; w.b_sel = OPB_XC;
        w.jmp_restart = 1'b1; w.jmp_tgt = LoadPc;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.a_sel = OPA_C; w.b_sel = OPB_VL;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.a_sel = OPA_K; w.b_sel = OPB_XL; w.alu_op = ALU_TS;
      end
      4'd3: begin
        w.mul_en = 1'b1; w.a_sel = OPA_TS; w.b_sel = OPB_XC; w.alu_op = ALU_ACC_LOAD;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.a_sel = OPA_DT; w.b_sel = OPB_VL; w.alu_op = ALU_ACC_FIN;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.a_sel = OPA_DT; w.b_sel = OPB_TA; w.alu_op = ALU_TS;
      end
      4'd6: begin
        w.mul_en = 1'b1; w.a_sel = OPA_K; w.b_sel = OPB_TS; w.alu_op = ALU_ADD_XL;
      end
      4'd7: begin
        w.mul_en = 1'b1; w.a_sel = OPA_C; w.b_sel = OPB_VC; w.alu_op = ALU_ADD_VL;
      end
      4'd8: begin
        w.mul_en = 1'b1; w.a_sel = OPA_DT; w.b_sel = OPB_VC; w.alu_op = ALU_ACC_LOAD;
      end
      4'd9: begin
        w.alu_op = ALU_ACC_FIN;
      end
      4'd10: begin
        w.mul_en = 1'b1; w.a_sel = OPA_DT; w.b_sel = OPB_TA; w.alu_op = ALU_ADD_XC;
      end
      4'd11: begin
        w.alu_op = ALU_NOP;
      end
      4'd12: begin
        w.alu_op = ALU_ADD_VC; w.last = 1'b1;
      end
      4'd13: begin
        w.alu_op = ALU_LOAD; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Clamp a 48-bit signed value to the 32-bit range.
  function automatic sat_t sat48(input logic signed [47:0] v);
    sat_t s;
    s.clip = ~((&v[47:31]) | ~(|v[47:31]));
    if (s.clip) begin
      s.val = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      s.val = v[31:0];
    end
    return s;
  endfunction

  // Clamp a 34-bit signed sum to the 32-bit range.
  function automatic sat_t sat34(input logic signed [33:0] v);
    sat_t s;
    s.clip = ~((&v[33:31]) | ~(|v[33:31]));
    if (s.clip) begin
      s.val = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      s.val = v[31:0];
    end
    return s;
  endfunction

  // Q16.16 product: add one half, then an arithmetic shift floors the
  // result, which rounds to nearest with ties toward plus infinity.
  function automatic sat_t round_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'(QHalf);
    return sat48(t[63:16]);
  endfunction

endpackage

// ----- sv/damped_oscillator_euler_diff_top.sv -----
// ----------------------------------------------------------------------------
// damped_oscillator_euler_diff_top: linear and cubic-spring Euler stepper
// Integrates a linear and a cubic-spring damped, forced oscillator side by
// side and reports their position and velocity difference in Q16.16.
// ----------------------------------------------------------------------------
// An item with restart high loads start_position and start_velocity into both
// oscillators and skips to the load word; any other item advances both by one
// time step. A step is paced by a single 32x32 multiplier that is shared by
// all ten products of a step, and by the cubic chain (x*x, x^3, k*x^3, dt*a)
// behind its product and rounding registers. An item is taken only in idle,
// so the block takes no new item before it is through with the last one. A
// new item is taken while the previous result waits in the output register; a
// finished item then waits for that register to empty. The user must write
// registers through the APB port only while no item is in flight; the block
// itself does not enforce this.
module damped_oscillator_euler_diff_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [doe_pkg::DataW-1:0]     out_position_difference,
  output logic signed [doe_pkg::DataW-1:0]     out_velocity_difference,
  output logic signed [doe_pkg::DataW-1:0]     out_linear_position_out,
  output logic signed [doe_pkg::DataW-1:0]     out_cubic_position_out,
  output logic                                 out_saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [doe_pkg::AddrW-1:0]            paddr,
  input  logic [doe_pkg::DataW-1:0]            pwdata,
  output logic [doe_pkg::DataW-1:0]            prdata,
  output logic                                 pready
);

  // Configuration registers
  logic signed [doe_pkg::DataW-1:0] damping_r, damping_nxt;
  logic signed [doe_pkg::DataW-1:0] stiff_r, stiff_nxt;
  logic signed [doe_pkg::DataW-1:0] forcing_r, forcing_nxt;
  logic [doe_pkg::StepW-1:0]        step_r, step_nxt;
  logic signed [doe_pkg::DataW-1:0] start_pos_r, start_pos_nxt;
  logic signed [doe_pkg::DataW-1:0] start_vel_r, start_vel_nxt;

  // Sequencer
  doe_pkg::seq_state_t       state_r, state_nxt;
  logic [doe_pkg::PcW-1:0]   pc_r, pc_nxt;
  logic                      restart_r, restart_nxt;
  logic                      flag_r, flag_nxt;
  logic                      pv1_r, pv1_nxt;
  doe_pkg::uword_t           uw;

  // Datapath
  logic signed [doe_pkg::DataW-1:0] xl_r, xl_nxt, vl_r, vl_nxt;
  logic signed [doe_pkg::DataW-1:0] xc_r, xc_nxt, vc_r, vc_nxt;
  logic signed [doe_pkg::DataW-1:0] ts_r, ts_nxt, ta_r, ta_nxt;
  logic signed [doe_pkg::DataW:0]   acc_r, acc_nxt;
  logic signed [63:0]               prod_r, prod_nxt;
  logic signed [doe_pkg::DataW-1:0] rq_r, rq_nxt;
  logic signed [doe_pkg::DataW-1:0] opa, opb, add_a;
  logic signed [doe_pkg::DataW:0]   add_sum, dp_sum, dv_sum;
  logic signed [doe_pkg::DataW+1:0] fin_sum;
  doe_pkg::sat_t                    rnd, alu_sat, dp_sat, dv_sat;
  logic                             alu_clip, run, mul_fire, out_load;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic signed [doe_pkg::DataW-1:0] odp_r, odp_nxt, odv_r, odv_nxt;
  logic signed [doe_pkg::DataW-1:0] oxl_r, oxl_nxt, oxc_r, oxc_nxt;
  logic                             osat_r, osat_nxt;

  doe_pkg::reg_idx_t                reg_idx;
  logic                             cfg_wr;

  assign reg_idx = doe_pkg::reg_idx_t'(paddr[doe_pkg::AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      doe_pkg::REG_DAMPING:   prdata = damping_r;
      doe_pkg::REG_STIFFNESS: prdata = stiff_r;
      doe_pkg::REG_FORCING:   prdata = forcing_r;
      doe_pkg::REG_TIME_STEP: prdata = {1'b0, step_r};
      doe_pkg::REG_START_POS: prdata = start_pos_r;
      doe_pkg::REG_START_VEL: prdata = start_vel_r;
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    damping_nxt   = damping_r;
    stiff_nxt     = stiff_r;
    forcing_nxt   = forcing_r;
    step_nxt      = step_r;
    start_pos_nxt = start_pos_r;
    start_vel_nxt = start_vel_r;
    if (cfg_wr) begin
      case (reg_idx)
        doe_pkg::REG_DAMPING:   damping_nxt   = pwdata;
        doe_pkg::REG_STIFFNESS: stiff_nxt     = pwdata;
        doe_pkg::REG_FORCING:   forcing_nxt   = pwdata;
        doe_pkg::REG_TIME_STEP: step_nxt      = pwdata[doe_pkg::StepW-1:0];
        doe_pkg::REG_START_POS: start_pos_nxt = pwdata;
        doe_pkg::REG_START_VEL: start_vel_nxt = pwdata;
        default: ;
      endcase
    end
  end

  // Multiplier and adder operand selection
  always_comb begin
    case (uw.a_sel)
      doe_pkg::OPA_C:  opa = damping_r;
      doe_pkg::OPA_K:  opa = stiff_r;
      doe_pkg::OPA_DT: opa = {1'b0, step_r};
      doe_pkg::OPA_XC: opa = xc_r;
      doe_pkg::OPA_TS: opa = ts_r;
      default:         opa = '0;
    endcase
    case (uw.b_sel)
      doe_pkg::OPB_VL: opb = vl_r;
      doe_pkg::OPB_XL: opb = xl_r;
      doe_pkg::OPB_VC: opb = vc_r;
      doe_pkg::OPB_XC: opb = xc_r;
      doe_pkg::OPB_TS: opb = ts_r;
      doe_pkg::OPB_TA: opb = ta_r;
      default:         opb = '0;
    endcase
    case (uw.alu_op)
      doe_pkg::ALU_ADD_XL: add_a = xl_r;
      doe_pkg::ALU_ADD_VL: add_a = vl_r;
      doe_pkg::ALU_ADD_XC: add_a = xc_r;
      default:             add_a = vc_r;
    endcase
  end

  always_comb begin
    uw       = doe_pkg::ucode(pc_r);
    run      = (state_r == doe_pkg::ST_RUN);
    mul_fire = run & uw.mul_en & ~(uw.jmp_restart & restart_r);

    prod_nxt = 64'(opa) * 64'(opb);
    rnd      = doe_pkg::round_q(prod_r);
    rq_nxt   = rnd.val;
    pv1_nxt  = mul_fire;

    add_sum  = 33'(add_a) + 33'(rq_r);
    fin_sum  = 34'(acc_r) - 34'(rq_r);
    dp_sum   = 33'(xl_r) - 33'(xc_r);
    dv_sum   = 33'(vl_r) - 33'(vc_r);
    dp_sat   = doe_pkg::sat34(34'(dp_sum));
    dv_sat   = doe_pkg::sat34(34'(dv_sum));

    state_nxt   = state_r;
    pc_nxt      = pc_r;
    restart_nxt = restart_r;
    flag_nxt    = flag_r;
    xl_nxt = xl_r;  vl_nxt = vl_r;  xc_nxt = xc_r;  vc_nxt = vc_r;
    ts_nxt = ts_r;  ta_nxt = ta_r;  acc_nxt = acc_r;
    alu_sat  = doe_pkg::sat34(34'(add_sum));
    alu_clip = 1'b0;

    odp_nxt = odp_r;  odv_nxt = odv_r;  oxl_nxt = oxl_r;  oxc_nxt = oxc_r;
    osat_nxt = osat_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_load = 1'b0;

    in_ready = (state_r == doe_pkg::ST_IDLE);

    case (state_r)
      doe_pkg::ST_IDLE: begin
        if (in_valid) begin
          restart_nxt = in_restart;
          flag_nxt    = 1'b0;
          pc_nxt      = '0;
          state_nxt   = doe_pkg::ST_RUN;
        end
      end
      doe_pkg::ST_RUN: begin
        case (uw.alu_op)
          doe_pkg::ALU_TS:       ts_nxt = rq_r;
          doe_pkg::ALU_ACC_LOAD: acc_nxt = 33'(forcing_r) - 33'(rq_r);
          doe_pkg::ALU_ACC_FIN: begin
            alu_sat  = doe_pkg::sat34(fin_sum);
            ta_nxt   = alu_sat.val;
            alu_clip = alu_sat.clip;
          end
          doe_pkg::ALU_ADD_XL: begin
            xl_nxt = alu_sat.val;  alu_clip = alu_sat.clip;
          end
          doe_pkg::ALU_ADD_VL: begin
            vl_nxt = alu_sat.val;  alu_clip = alu_sat.clip;
          end
          doe_pkg::ALU_ADD_XC: begin
            xc_nxt = alu_sat.val;  alu_clip = alu_sat.clip;
          end
          doe_pkg::ALU_ADD_VC: begin
            vc_nxt = alu_sat.val;  alu_clip = alu_sat.clip;
          end
          doe_pkg::ALU_LOAD: begin
            xl_nxt = start_pos_r;  xc_nxt = start_pos_r;
            vl_nxt = start_vel_r;  vc_nxt = start_vel_r;
          end
          default: ;
        endcase
        flag_nxt = flag_r | (pv1_r & rnd.clip) | alu_clip;
        if (uw.last) begin
          pc_nxt    = '0;
          state_nxt = doe_pkg::ST_DONE;
        end else if (uw.jmp_restart && restart_r) begin
          pc_nxt = uw.jmp_tgt;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      doe_pkg::ST_DONE: begin
        // Hold here until the previous result has left the output register.
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = doe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = doe_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      odp_nxt  = dp_sat.val;
      odv_nxt  = dv_sat.val;
      oxl_nxt  = xl_r;
      oxc_nxt  = xc_r;
      osat_nxt = flag_r | dp_sat.clip | dv_sat.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r   <= doe_pkg::DampingReset;
      stiff_r     <= doe_pkg::StiffReset;
      forcing_r   <= doe_pkg::ForcingReset;
      step_r      <= doe_pkg::StepReset;
      start_pos_r <= doe_pkg::StartPosReset;
      start_vel_r <= doe_pkg::StartVelReset;
      state_r     <= doe_pkg::ST_IDLE;
      pc_r        <= '0;
      restart_r   <= 1'b0;
      flag_r      <= 1'b0;
      pv1_r       <= 1'b0;
      out_valid_r <= 1'b0;
      xl_r        <= '0;
      vl_r        <= '0;
      xc_r        <= '0;
      vc_r        <= '0;
    end else begin
      damping_r   <= damping_nxt;
      stiff_r     <= stiff_nxt;
      forcing_r   <= forcing_nxt;
      step_r      <= step_nxt;
      start_pos_r <= start_pos_nxt;
      start_vel_r <= start_vel_nxt;
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      restart_r   <= restart_nxt;
      flag_r      <= flag_nxt;
      pv1_r       <= pv1_nxt;
      out_valid_r <= out_valid_nxt;
      xl_r        <= xl_nxt;
      vl_r        <= vl_nxt;
      xc_r        <= xc_nxt;
      vc_r        <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r   <= ts_nxt;
    ta_r   <= ta_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    rq_r   <= rq_nxt;
    odp_r  <= odp_nxt;
    odv_r  <= odv_nxt;
    oxl_r  <= oxl_nxt;
    oxc_r  <= oxc_nxt;
    osat_r <= osat_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_position_difference = odp_r;
  assign out_velocity_difference = odv_r;
  assign out_linear_position_out = oxl_r;
  assign out_cubic_position_out  = oxc_r;
  assign out_saturated           = osat_r;

endmodule

// ----- sv/doe_checker.sv -----
// ----------------------------------------------------------------------------
// doe_checker: port-level checks for the oscillator stepper
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module doe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_restart,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [doe_pkg::DataW-1:0] out_position_difference,
  input logic signed [doe_pkg::DataW-1:0] out_velocity_difference,
  input logic signed [doe_pkg::DataW-1:0] out_linear_position_out,
  input logic signed [doe_pkg::DataW-1:0] out_cubic_position_out,
  input logic                             out_saturated
);

  logic [1:0] pend_r, pend_nxt;
  logic       last_restart_r, last_restart_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  always_comb begin
    pend_nxt         = pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    last_restart_nxt = in_xfer ? in_restart : last_restart_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r         <= '0;
      last_restart_r <= 1'b0;
    end else begin
      pend_r         <= pend_nxt;
      last_restart_r <= last_restart_nxt;
    end
  end

  // A result that waits stays valid and keeps its differences and saturation flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position_difference)
      && $stable(out_velocity_difference) && $stable(out_saturated))
    else $error("result changed while stalled");

  // Items are worked one at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is still in work");

  // Every result belongs to an accepted item, and at most one more waits behind it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r == 2'd1 || pend_r == 2'd2))
    else $error("result without a matching item");

  // A restart leaves both oscillators in the same state with nothing clamped.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && pend_r == 2'd1 && last_restart_r |->
      out_position_difference == '0 && out_velocity_difference == '0
      && out_linear_position_out == out_cubic_position_out && !out_saturated)
    else $error("restart result not symmetric");

endmodule

bind damped_oscillator_euler_diff_top doe_checker u_doe_checker (.*);

// ----- tb/tb_damped_oscillator_euler_diff_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_damped_oscillator_euler_diff_top: self-checking bench for the Euler stepper
// Drives restart and step items through the valid/ready input, programs the
// six coefficient registers over APB between runs, and checks every result
// against a cycle-free Q16.16 prediction of both oscillators.
// ----------------------------------------------------------------------------
module tb_damped_oscillator_euler_diff_top;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned RandomItems = 750;

  typedef struct packed {
    logic signed [doe_pkg::DataW-1:0] pos_diff;
    logic signed [doe_pkg::DataW-1:0] vel_diff;
    logic signed [doe_pkg::DataW-1:0] lin_pos;
    logic signed [doe_pkg::DataW-1:0] cub_pos;
    logic                             saturated;
  } osc_result_t;

  // Tracks both oscillators and the coefficient registers, and holds the
  // results still owed by the block, oldest first.
  class oscillator_pair_tracker;
    longint c_q, k_q, g_q, dt_q, x0_q, v0_q;
    longint xl, vl, xc, vc;
    bit clipped;
    osc_result_t predicted_steps[$];
    int unsigned errors, checked, restarts, steps;

    function new();
      c_q = 65536;
      k_q = 65536;
      g_q = 655360;
      dt_q = 6554;
      x0_q = 65536;
      v0_q = 0;
      xl = 0;
      vl = 0;
      xc = 0;
      vc = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] data);
      case (idx)
        doe_pkg::REG_DAMPING:   c_q = $signed(data);
        doe_pkg::REG_STIFFNESS: k_q = $signed(data);
        doe_pkg::REG_FORCING:   g_q = $signed(data);
        doe_pkg::REG_TIME_STEP: dt_q = data[30:0];
        doe_pkg::REG_START_POS: x0_q = $signed(data);
        doe_pkg::REG_START_VEL: v0_q = $signed(data);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > QMax) begin
        clipped = 1'b1;
        return QMax;
      end
      if (v < QMin) begin
        clipped = 1'b1;
        return QMin;
      end
      return v;
    endfunction

    // The arithmetic shift floors, so adding one half first rounds to
    // nearest with ties toward plus infinity.
    function longint mul_q(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return clamp32(p >>> 16);
    endfunction

    function void advance_one(input longint x, input longint v, input bit cubic,
                              output longint nx, output longint nv);
      longint spring, acc;
      spring = cubic ? mul_q(mul_q(x, x), x) : x;
      acc = clamp32(g_q - mul_q(c_q, v) - mul_q(k_q, spring));
      nx = clamp32(x + mul_q(dt_q, v));
      nv = clamp32(v + mul_q(dt_q, acc));
    endfunction

    function void note_transfer(bit restart);
      osc_result_t r;
      longint nxl, nvl, nxc, nvc, dp, dv;
      clipped = 1'b0;
      if (restart) begin
        xl = x0_q;
        vl = v0_q;
        xc = x0_q;
        vc = v0_q;
        restarts++;
      end else begin
        advance_one(xl, vl, 1'b0, nxl, nvl);
        advance_one(xc, vc, 1'b1, nxc, nvc);
        xl = nxl;
        vl = nvl;
        xc = nxc;
        vc = nvc;
        steps++;
      end
      dp = clamp32(xl - xc);
      dv = clamp32(vl - vc);
      r.pos_diff = dp[31:0];
      r.vel_diff = dv[31:0];
      r.lin_pos = xl[31:0];
      r.cub_pos = xc[31:0];
      r.saturated = clipped;
      predicted_steps.push_back(r);
    endfunction

    function void compare_field(string what, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_step(osc_result_t got);
      osc_result_t want;
      if (predicted_steps.size() == 0) begin
        $display("%0t: result transfer with nothing predicted", $time);
        errors++;
        return;
      end
      want = predicted_steps.pop_front();
      checked++;
      compare_field("position_difference", want.pos_diff, got.pos_diff);
      compare_field("velocity_difference", want.vel_diff, got.vel_diff);
      compare_field("linear_position_out", want.lin_pos, got.lin_pos);
      compare_field("cubic_position_out", want.cub_pos, got.cub_pos);
      compare_field("saturated", {63'd0, want.saturated}, {63'd0, got.saturated});
    endfunction

    function int unsigned pending();
      return predicted_steps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [doe_pkg::DataW-1:0] out_position_difference;
  logic signed [doe_pkg::DataW-1:0] out_velocity_difference;
  logic signed [doe_pkg::DataW-1:0] out_linear_position_out;
  logic signed [doe_pkg::DataW-1:0] out_cubic_position_out;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [doe_pkg::AddrW-1:0] paddr = '0;
  logic [doe_pkg::DataW-1:0] pwdata = '0;
  logic [doe_pkg::DataW-1:0] prdata;
  logic pready;

  oscillator_pair_tracker sb = new();
  int unsigned cycles = 0;
  bit squeeze_req = 1'b0;

  damped_oscillator_euler_diff_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_restart              (in_restart),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_position_difference (out_position_difference),
    .out_velocity_difference (out_velocity_difference),
    .out_linear_position_out (out_linear_position_out),
    .out_cubic_position_out  (out_cubic_position_out),
    .out_saturated           (out_saturated),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] draw_setting(int unsigned idx);
    int unsigned r, span;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 16) return $urandom();
    case (idx)
      doe_pkg::REG_DAMPING:   span = 131072;
      doe_pkg::REG_STIFFNESS: span = 262144;
      doe_pkg::REG_FORCING:   span = 1048576;
      doe_pkg::REG_TIME_STEP: return $urandom_range(0, 16384);
      default:                span = 262144;
    endcase
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic apb_write(input int unsigned idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= doe_pkg::AddrW'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] c, input logic [31:0] k,
                               input logic [31:0] g, input logic [31:0] dt,
                               input logic [31:0] x0, input logic [31:0] v0);
    apb_write(doe_pkg::REG_DAMPING, c);
    apb_write(doe_pkg::REG_STIFFNESS, k);
    apb_write(doe_pkg::REG_FORCING, g);
    apb_write(doe_pkg::REG_TIME_STEP, dt);
    apb_write(doe_pkg::REG_START_POS, x0);
    apb_write(doe_pkg::REG_START_VEL, v0);
  endtask

  task automatic send_item(input bit restart, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(restart);
  endtask

  // Wait for the block to drain so the registers can be touched safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off that
  // lets the block back up into its input.
  initial begin
    int unsigned stall_left, mode_timer;
    bit calm, squeeze_done;
    osc_result_t got;
    stall_left = 0;
    mode_timer = 0;
    calm = 1'b0;
    squeeze_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.pos_diff = out_position_difference;
        got.vel_diff = out_velocity_difference;
        got.lin_pos = out_linear_position_out;
        got.cub_pos = out_cubic_position_out;
        got.saturated = out_saturated;
        sb.check_step(got);
      end
      if (mode_timer == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_timer = 64;
      end else begin
        mode_timer--;
      end
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = random_gap();
        out_ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    int unsigned sent_random, run_len, settings;
    bit steady, restart;
    sent_random = 0;
    settings = 1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients; the first steps integrate from the all-zero state.
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    repeat (3) send_item(1'b0, 1'b0);

    // Extreme coefficients in both directions, aimed at the clamping paths.
    settle();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    settings++;
    send_item(1'b1, 1'b0);
    repeat (3) send_item(1'b0, 1'b0);

    settle();
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    settings++;
    send_item(1'b1, 1'b0);
    repeat (2) send_item(1'b0, 1'b0);

    // Writes to unmapped indexes, followed by a full reload of all six registers.
    settle();
    apb_write(6, $urandom());
    apb_write(7, $urandom());
    load_settings(32'h0000_8000, 32'h0002_0000, 32'h0001_0000,
                  32'h0000_0CCD, 32'hFFFE_8000, 32'h0000_C000);
    settings++;
    send_item(1'b1, 1'b0);
    repeat (3) send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);

    while (sent_random < RandomItems) begin
      settle();
      for (int unsigned idx = 0; idx < 6; idx++) begin
        if ($urandom_range(0, 99) < 60) apb_write(idx, draw_setting(idx));
      end
      if ($urandom_range(0, 9) == 0) apb_write($urandom_range(6, 7), $urandom());
      settings++;
      run_len = $urandom_range(10, 60);
      steady = ($urandom_range(0, 3) == 0);
      if (settings == 7) begin
        steady = 1'b1;
        run_len = 40;
        squeeze_req = 1'b1;
      end
      for (int unsigned i = 0; i < run_len; i++) begin
        restart = (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 24) == 0);
        send_item(restart, steady);
        sent_random++;
      end
    end
    settle();

    $display("Covered %0d restarts and %0d Euler steps over %0d register settings.",
             sb.restarts, sb.steps, settings);
    $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/doe_pkg.sv
sv/damped_oscillator_euler_diff_top.sv
sv/doe_checker.sv
tb/tb_damped_oscillator_euler_diff_top.sv
